@@ design/sfd_pkg.sv @@
// Shared constants, types and helpers for the sensor frame deframer.
package sfd_pkg;

    // Frame layout
    localparam int unsigned FRAME_BYTES = 15;
    localparam int unsigned FILL_W      = $clog2(FRAME_BYTES + 1);

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FRAME_BYTES);
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(FRAME_BYTES - 1);

    // Sync pattern at the head of a frame
    localparam logic [7:0] SYNC0 = 8'h00;
    localparam logic [7:0] SYNC1 = 8'hF0;
    localparam logic [7:0] SYNC2 = 8'h0F;

    // Byte positions within the frame
    localparam int unsigned POS_SOIL_HI = 3;
    localparam int unsigned POS_SOIL_LO = 4;
    localparam int unsigned POS_TEMP_W  = 6;
    localparam int unsigned POS_TEMP_T  = 7;
    localparam int unsigned POS_HUM_W   = 9;
    localparam int unsigned POS_HUM_T   = 10;
    localparam int unsigned POS_UV      = 12;
    localparam int unsigned POS_SUM     = 14;

    typedef logic [7:0] t_byte;

    // One decoded sensor reading
    typedef struct packed {
        logic [15:0] soil_moisture;
        logic [11:0] temperature_tenths;
        logic [11:0] humidity_tenths;
        logic [7:0]  uv_level;
    } t_result;

    // whole * 10 + tenth, exact in 12 bits (max 2805)
    function automatic logic [11:0] tenths(input t_byte whole, input t_byte tenth);
        logic [11:0] w;
        begin
            w = {4'b0, whole};
            return (w << 3) + (w << 1) + {4'b0, tenth};
        end
    endfunction

endpackage

@@ design/sfd_if.sv @@
// Valid/ready channel interfaces for the deframer input and result items.

interface sfd_in_if
    import sfd_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte rx_byte;
    logic  buffer_end;

    modport source (output valid, output rx_byte, output buffer_end, input ready);
    modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

interface sfd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] soil_moisture;
    logic [11:0] temperature_tenths;
    logic [11:0] humidity_tenths;
    logic [7:0]  uv_level;

    modport source (output valid, output soil_moisture, output temperature_tenths,
                    output humidity_tenths, output uv_level, input ready);
    modport sink   (input valid, input soil_moisture, input temperature_tenths,
                    input humidity_tenths, input uv_level, output ready);
endinterface

@@ design/sensor_frame_deframer_top.sv @@
// Sensor frame deframer: sliding 15-byte window, sync/sum check, result output.
//
// Takes one received byte per cycle while input ready is high into a 15-byte
// sliding window and, once the window is full, checks it for the sync bytes 00 F0 0F
// and an 8-bit sum of the seven field bytes against the last byte. The first good
// frame of a buffer produces one reading (soil moisture, temperature and humidity in
// tenths, UV level); later frames are ignored until a byte flagged buffer_end, after
// which the window fill and the taken flag clear. The shift, the compare and the
// seven-byte sum all sit between the window registers and the result register, so
// a byte can be accepted each cycle while input ready is high.
// The result sits in an output register backed by one skid entry; input ready
// drops only while that skid entry is occupied by a stalled reading.
module sensor_frame_deframer_top
    import sfd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfd_in_if.sink    i_in,
    sfd_out_if.source o_out
);

    // Window, fill count and taken flag
    t_byte             r_win [FRAME_BYTES];
    logic [FILL_W-1:0] r_fill;
    logic              r_taken;

    // Output register and skid entry
    t_result r_out;
    logic    r_out_valid;
    t_result r_skid;
    logic    r_skid_valid;

    logic    w_in_fire;
    logic    w_out_fire;
    t_byte   w_win [FRAME_BYTES];
    logic    w_sync_ok;
    t_byte   w_sum;
    logic    w_hit;
    t_result w_res;

    assign i_in.ready = !r_skid_valid;
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_fire = o_out.valid && o_out.ready;

    // Window as it stands after the incoming byte is shifted in
    always_comb begin
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            w_win[i] = r_win[i+1];
        end
        w_win[FRAME_BYTES-1] = i_in.rx_byte;
    end

    // Frame check: sync bytes and 8-bit payload sum
    always_comb begin
        w_sync_ok = (w_win[0] == SYNC0) && (w_win[1] == SYNC1) && (w_win[2] == SYNC2);
        w_sum     = w_win[POS_SOIL_HI] + w_win[POS_SOIL_LO] + w_win[POS_TEMP_W]
                  + w_win[POS_TEMP_T] + w_win[POS_HUM_W] + w_win[POS_HUM_T]
                  + w_win[POS_UV];
        // window is full after this byte when at least FRAME_BYTES-1 were held
        w_hit     = w_in_fire && (r_fill >= FILL_LAST) && !r_taken && w_sync_ok
                  && (w_sum == w_win[POS_SUM]);
    end

    // Field decode
    always_comb begin
        w_res.soil_moisture      = {w_win[POS_SOIL_HI], w_win[POS_SOIL_LO]};
        w_res.temperature_tenths = tenths(w_win[POS_TEMP_W], w_win[POS_TEMP_T]);
        w_res.humidity_tenths    = tenths(w_win[POS_HUM_W], w_win[POS_HUM_T]);
        w_res.uv_level           = w_win[POS_UV];
    end

    // Window shift; contents need no clear since fill gates the check
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            for (int i = 0; i < FRAME_BYTES; i++) begin
                r_win[i] <= w_win[i];
            end
        end
    end

    // Fill count and taken flag, cleared after a buffer end byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_taken <= 1'b0;
        end else if (w_in_fire) begin
            if (i_in.buffer_end) begin
                r_fill  <= '0;
                r_taken <= 1'b0;
            end else begin
                if (r_fill != FILL_FULL) begin
                    r_fill <= r_fill + 1'b1;
                end
                if (w_hit) begin
                    r_taken <= 1'b1;
                end
            end
        end
    end

    // Output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || o_out.ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_hit;
            end
        end else if (w_hit) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || o_out.ready) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_hit) begin
            r_skid <= w_res;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.soil_moisture      = r_out.soil_moisture;
    assign o_out.temperature_tenths = r_out.temperature_tenths;
    assign o_out.humidity_tenths    = r_out.humidity_tenths;
    assign o_out.uv_level           = r_out.uv_level;

    // Skid entry is only used behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // A held reading in the skid entry is not lost
    a_skid_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !w_out_fire) |=> r_skid_valid)
        else $error("skid entry dropped while output stalled");

    // A good frame blocks further frames in the buffer
    a_taken_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_hit && !i_in.buffer_end) |=> r_taken)
        else $error("taken flag not set after good frame");

    // Buffer end clears the search state
    a_buf_end_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_in.buffer_end) |=> (r_fill == '0 && !r_taken))
        else $error("state not cleared after buffer end");

    // A hit only comes from a window that is full after the shift
    a_hit_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hit |-> (r_fill >= FILL_LAST))
        else $error("frame hit on partial window");

endmodule

@@ dv/sensor_frame_deframer_top_tb.sv @@
// Self-checking testbench for the sensor frame deframer: byte stimulus, scoreboard, stall phases.
module sensor_frame_deframer_top_tb
    import sfd_pkg::*;
;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES = 300;

    typedef enum int {FRM_GOOD, FRM_BAD_SUM, FRM_BAD_SYNC} t_frame_kind;
    typedef enum int {TAIL_NONE, TAIL_FRAME, TAIL_NOISE} t_tail;

    // Tracks the deframer window and holds the readings it should produce
    class frame_scoreboard;
        t_byte       win [FRAME_BYTES];
        int unsigned fill;
        bit          taken;
        t_result     readings_q [$];
        int unsigned errors;
        int unsigned readings_seen;

        function new();
            clear();
            errors        = 0;
            readings_seen = 0;
        endfunction

        function void clear();
            foreach (win[i]) win[i] = '0;
            fill  = 0;
            taken = 1'b0;
        endfunction

        function int pending();
            return readings_q.size();
        endfunction

        // Shift one accepted byte in and predict the reading it causes
        function void note_byte(t_byte b, logic last);
            t_byte   sum;
            t_result r;
            for (int i = 0; i < FRAME_BYTES - 1; i++) win[i] = win[i + 1];
            win[FRAME_BYTES - 1] = b;
            if (fill < FRAME_BYTES) fill++;
            // 8-bit wrap is intended
            sum = win[POS_SOIL_HI] + win[POS_SOIL_LO] + win[POS_TEMP_W] + win[POS_TEMP_T]
                + win[POS_HUM_W] + win[POS_HUM_T] + win[POS_UV];
            if (fill == FRAME_BYTES && !taken && win[0] == SYNC0 && win[1] == SYNC1 &&
                win[2] == SYNC2 && sum == win[POS_SUM]) begin
                r.soil_moisture      = {win[POS_SOIL_HI], win[POS_SOIL_LO]};
                r.temperature_tenths = 12'(win[POS_TEMP_W]) * 12'd10 + 12'(win[POS_TEMP_T]);
                r.humidity_tenths    = 12'(win[POS_HUM_W]) * 12'd10 + 12'(win[POS_HUM_T]);
                r.uv_level           = win[POS_UV];
                readings_q.push_back(r);
                taken = 1'b1;
            end
            // buffer end clears everything after the byte is checked
            if (last) clear();
        endfunction

        // Compare one delivered reading against the oldest prediction
        function void check_reading(t_result got);
            t_result exp;
            readings_seen++;
            if (readings_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected reading soil=%h temp=%h hum=%h uv=%h", $time,
                         got.soil_moisture, got.temperature_tenths, got.humidity_tenths,
                         got.uv_level);
                return;
            end
            exp = readings_q.pop_front();
            if (got.soil_moisture !== exp.soil_moisture) begin
                errors++;
                $display("%0t: soil_moisture expected %h got %h", $time,
                         exp.soil_moisture, got.soil_moisture);
            end
            if (got.temperature_tenths !== exp.temperature_tenths) begin
                errors++;
                $display("%0t: temperature_tenths expected %h got %h", $time,
                         exp.temperature_tenths, got.temperature_tenths);
            end
            if (got.humidity_tenths !== exp.humidity_tenths) begin
                errors++;
                $display("%0t: humidity_tenths expected %h got %h", $time,
                         exp.humidity_tenths, got.humidity_tenths);
            end
            if (got.uv_level !== exp.uv_level) begin
                errors++;
                $display("%0t: uv_level expected %h got %h", $time,
                         exp.uv_level, got.uv_level);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    sfd_in_if  in_if();
    sfd_out_if out_if();

    sensor_frame_deframer_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    frame_scoreboard sb;
    int unsigned     bytes_sent;
    int unsigned     cycles = 0;
    int unsigned     in_idle_pct;
    int unsigned     out_stall_pct;
    int unsigned     hold_req;
    int unsigned     hold_seen = 0;
    int unsigned     hold_left = 0;
    t_result         got;

    // Clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("sensor_frame_deframer_top_tb: done, errors");
            $finish;
        end
    end

    // Result side: check accepted readings, then pick ready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.soil_moisture      = out_if.soil_moisture;
            got.temperature_tenths = out_if.temperature_tenths;
            got.humidity_tenths    = out_if.humidity_tenths;
            got.uv_level           = out_if.uv_level;
            sb.check_reading(got);
        end
        // a new hold request starts a long stall
        if (hold_req != hold_seen) begin
            hold_left = HOLD_CYCLES;
            hold_seen = hold_req;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= out_stall_pct);
        end
    end

    // One byte item, with random idle cycles in front
    task automatic send_byte(input t_byte b, input logic last);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.rx_byte    <= b;
        in_if.buffer_end <= last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    // Drop valid and wait for every predicted reading to arrive
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic send_noise(input int unsigned n, input logic end_last);
        for (int unsigned i = 0; i < n; i++)
            send_byte(t_byte'($urandom_range(0, 255)), end_last && (i == n - 1));
    endtask

    // Full 15-byte frame with random payload; optionally corrupted
    task automatic send_frame(input t_frame_kind kind, input logic end_last);
        t_byte       f [FRAME_BYTES];
        t_byte       sum;
        int unsigned idx;
        f[0] = SYNC0;
        f[1] = SYNC1;
        f[2] = SYNC2;
        for (int i = 3; i < FRAME_BYTES; i++) f[i] = t_byte'($urandom_range(0, 255));
        // tenth bytes mostly in 0..9, sometimes anything
        if ($urandom_range(0, 99) < 80) f[POS_TEMP_T] = t_byte'($urandom_range(0, 9));
        if ($urandom_range(0, 99) < 80) f[POS_HUM_T] = t_byte'($urandom_range(0, 9));
        sum = f[POS_SOIL_HI] + f[POS_SOIL_LO] + f[POS_TEMP_W] + f[POS_TEMP_T]
            + f[POS_HUM_W] + f[POS_HUM_T] + f[POS_UV];
        f[POS_SUM] = sum;
        if (kind == FRM_BAD_SUM) begin
            f[POS_SUM] = sum + t_byte'($urandom_range(1, 255));
        end else if (kind == FRM_BAD_SYNC) begin
            idx    = $urandom_range(0, 2);
            f[idx] = f[idx] ^ t_byte'($urandom_range(1, 255));
        end
        for (int i = 0; i < FRAME_BYTES; i++)
            send_byte(f[i], end_last && (i == FRAME_BYTES - 1));
    endtask

    // One buffer: mostly framed traffic, some noise and short buffers
    task automatic send_random_buffer();
        int unsigned pick;
        int unsigned k;
        t_tail       tail;
        t_frame_kind kind;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            send_noise($urandom_range(0, 6), 1'b0);
            if (pick < 60) kind = FRM_GOOD;
            else if (pick < 72) kind = FRM_BAD_SUM;
            else kind = FRM_BAD_SYNC;
            tail = t_tail'($urandom_range(0, 2));
            send_frame(kind, tail == TAIL_NONE);
            if (tail == TAIL_FRAME) send_frame(FRM_GOOD, 1'b1);
            else if (tail == TAIL_NOISE) send_noise($urandom_range(1, 5), 1'b1);
        end else if (pick < 90) begin
            send_noise($urandom_range(1, 30), 1'b1);
        end else begin
            // short buffer that ends before the window fills
            k = $urandom_range(1, FRAME_BYTES - 1);
            for (int unsigned i = 0; i < k; i++) begin
                if (i == 0) send_byte(SYNC0, k == 1);
                else if (i == 1) send_byte(SYNC1, k == 2);
                else if (i == 2) send_byte(SYNC2, k == 3);
                else send_byte(t_byte'($urandom_range(0, 255)), i == k - 1);
            end
        end
    endtask

    // Main stimulus
    initial begin
        logic [8*FRAME_BYTES-1:0] dir_frame;
        int unsigned              idle_tab [4];
        int unsigned              stall_tab [4];
        int unsigned              start_items;
        int unsigned              start_seen;

        sb          = new();
        bytes_sent  = 0;
        hold_req    = 0;
        in_idle_pct = 0;
        out_stall_pct = 0;
        idle_tab    = '{0, 46, 0, 30};
        stall_tab   = '{0, 0, 46, 30};

        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.rx_byte    <= '0;
        in_if.buffer_end <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Frame straight after reset: max soil, max temperature with tenth 255,
        // zero humidity, max UV; the payload sum wraps
        dir_frame = 120'h00F00F_FFFF5A_FFFFA5_00003C_FFC3FB;
        for (int i = FRAME_BYTES - 1; i >= 0; i--) send_byte(dir_frame[8*i +: 8], 1'b0);
        // buffer end on a byte after the taken frame
        send_byte(8'h00, 1'b1);
        // sync only, window never fills before the buffer ends
        send_byte(SYNC0, 1'b0);
        send_byte(SYNC1, 1'b0);
        send_byte(SYNC2, 1'b1);
        wait_drained();

        // Random phases with different idle and stall rates
        for (int p = 0; p < 4; p++) begin
            in_idle_pct   = idle_tab[p];
            out_stall_pct = stall_tab[p];
            start_items   = bytes_sent;
            start_seen    = sb.readings_seen;
            while (bytes_sent - start_items < 275 || sb.readings_seen - start_seen < 12) begin
                send_random_buffer();
                if ($urandom_range(0, 99) < 5) wait_drained();
            end

            // Back-pressure: receiver holds off while good frames keep coming
            if (p == 0) begin
                wait_drained();
                hold_req++;
                for (int n = 0; n < 5; n++) send_frame(FRM_GOOD, 1'b1);
                wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("sensor_frame_deframer_top_tb: done, clean");
        end else begin
            $display("sensor_frame_deframer_top_tb: done, errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/sfd_pkg.sv
design/sfd_if.sv
design/sensor_frame_deframer_top.sv
dv/sensor_frame_deframer_top_tb.sv
